/* sv/http_header_name_classifier_macros.svh */
// ----------------------------------------------------------------------------
// http header name classifier assertion macros
// Small wrappers for the concurrent checks, sampled on i_clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_NAME_CLASSIFIER_MACROS_SVH
`define HTTP_HEADER_NAME_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define HHNC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("hhnc check failed");

// next-cycle implication
`define HHNC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("hhnc check failed");

`endif

/* sv/hhnc_pkg.sv */
// ----------------------------------------------------------------------------
// hhnc_pkg
// Shared constants, name table and types for the header name classifier.
// ----------------------------------------------------------------------------
package hhnc_pkg;

    localparam int NAME_COUNT   = 39;
    localparam int LONGEST_NAME = 25;
    localparam int POS_W        = 5;
    localparam int ID_W         = 6;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(LONGEST_NAME);

    // names are right-justified: last character in bits [7:0]
    localparam logic [8*LONGEST_NAME-1:0] NAMES [NAME_COUNT] = '{
        "te", "via", "age", "date", "from", "host", "range",
        "origin", "pragma", "accept", "cookie", "expect",
        "warning", "upgrade", "trailer", "referer",
        "location", "if-range", "if-match",
        "user-agent", "set-cookie", "set-cookie2",
        "max-forwards", "content-type",
        "if-none-match", "cache-control", "authorization", "last-modified",
        "accept-charset", "content-length",
        "accept-encoding", "accept-language",
        "content-language",
        "if-modified-since", "transfer-encoding",
        "if-unmodified-since", "proxy-authorization",
        "upgrade-insecure-requests", "content-transfer-encoding"
    };

    localparam logic [POS_W-1:0] NAME_LEN [NAME_COUNT] = '{
        5'd2,  5'd3,  5'd3,  5'd4,  5'd4,  5'd4,  5'd5,
        5'd6,  5'd6,  5'd6,  5'd6,  5'd6,
        5'd7,  5'd7,  5'd7,  5'd7,
        5'd8,  5'd8,  5'd8,
        5'd10, 5'd10, 5'd11,
        5'd12, 5'd12,
        5'd13, 5'd13, 5'd13, 5'd13,
        5'd14, 5'd14,
        5'd15, 5'd15,
        5'd16,
        5'd17, 5'd17,
        5'd19, 5'd19,
        5'd25, 5'd25
    };

    typedef logic [NAME_COUNT-1:0] t_alive;

    typedef struct packed {
        t_alive            alive;
        logic [ID_W-1:0]   id;
    } t_match;

    // character of table name idx at position pos, zero past its end
    function automatic logic [7:0] name_char(input int idx, input logic [POS_W-1:0] pos);
        logic [7:0] c;
        c = 8'h00;
        for (int k = 0; k < LONGEST_NAME; k++) begin
            if (pos == POS_W'(k) && k < int'(NAME_LEN[idx])) begin
                c = NAMES[idx][8*(int'(NAME_LEN[idx])-1-k) +: 8];
            end
        end
        return c;
    endfunction

endpackage

/* sv/hhnc_match.sv */
// ----------------------------------------------------------------------------
// hhnc_match
// Folds one byte and compares it against every table name at its position.
// ----------------------------------------------------------------------------
module hhnc_match (
    input  logic [7:0]                 i_byte,
    input  logic [hhnc_pkg::POS_W-1:0] i_pos,
    input  hhnc_pkg::t_alive           i_alive,
    output hhnc_pkg::t_match           o_match
);

    logic [7:0]              folded;
    hhnc_pkg::t_alive        alive_nxt;
    logic [hhnc_pkg::POS_W:0] pos_plus;
    logic [hhnc_pkg::ID_W-1:0] id;

    always_comb begin
        folded = i_byte;
        if (i_byte inside {[8'h41:8'h5A]}) begin
            folded = i_byte + 8'h20;
        end
    end

    always_comb begin
        for (int i = 0; i < hhnc_pkg::NAME_COUNT; i++) begin
            alive_nxt[i] = i_alive[i]
                && (i_pos < hhnc_pkg::POS_MAX)
                && (i_pos < hhnc_pkg::NAME_LEN[i])
                && (hhnc_pkg::name_char(i, i_pos) == folded);
        end
    end

    assign pos_plus = {1'b0, i_pos} + 1'b1;

    // lowest table index whose length ends here wins
    always_comb begin
        id = '0;
        for (int i = hhnc_pkg::NAME_COUNT - 1; i >= 0; i--) begin
            if (alive_nxt[i] && {1'b0, hhnc_pkg::NAME_LEN[i]} == pos_plus) begin
                id = hhnc_pkg::ID_W'(i + 1);
            end
        end
    end

    assign o_match.alive = alive_nxt;
    assign o_match.id    = id;

endmodule

/* sv/http_header_name_classifier.sv */
// ----------------------------------------------------------------------------
// http_header_name_classifier
// Case-insensitive match of a streamed header name against 39 known names.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_name_byte, i_last_byte
//  result  | out       | o_valid / i_stall  | o_header_id, o_recognized
//
//  one byte per cycle while o_stall is low; a byte is held in the input register,
//  is compared there, and the result of a last byte is registered for output.
//  reset is synchronous on i_rst_n, no sweep.
//  a held result stalls input only when the byte in the input register is a
//  last byte; other bytes keep flowing under an output stall.
// ----------------------------------------------------------------------------
`include "http_header_name_classifier_macros.svh"

module http_header_name_classifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_name_byte,
    input  logic                        i_last_byte,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hhnc_pkg::ID_W-1:0]   o_header_id,
    output logic                        o_recognized
);

    logic                       r_s1_valid, n_s1_valid;
    logic [7:0]                 r_s1_byte;
    logic                       r_s1_last;
    hhnc_pkg::t_alive           r_alive, n_alive;
    logic [hhnc_pkg::POS_W-1:0] r_pos, n_pos;
    logic                       r_out_valid, n_out_valid;
    logic [hhnc_pkg::ID_W-1:0]  r_out_id;

    hhnc_pkg::t_match match;
    logic             s1_go;
    logic             in_xfer;
    logic             out_load;

    hhnc_match u_match (
        .i_byte  (r_s1_byte),
        .i_pos   (r_pos),
        .i_alive (r_alive),
        .o_match (match)
    );

    assign s1_go    = r_s1_valid && (!r_s1_last || !r_out_valid || !i_stall);
    assign o_stall  = r_s1_valid && !s1_go;
    assign in_xfer  = i_valid && !o_stall;
    assign out_load = s1_go && r_s1_last;

    always_comb begin
        n_s1_valid = in_xfer || (r_s1_valid && !s1_go);
        n_alive    = r_alive;
        n_pos      = r_pos;
        if (s1_go) begin
            if (r_s1_last) begin
                n_alive = '1;
                n_pos   = '0;
            end else begin
                n_alive = match.alive;
                if (r_pos < hhnc_pkg::POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
        n_out_valid = out_load || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_alive     <= '1;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_alive     <= n_alive;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_byte <= i_name_byte;
            r_s1_last <= i_last_byte;
        end
        if (out_load) begin
            r_out_id <= match.id;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_header_id  = r_out_id;
    assign o_recognized = (r_out_id != '0);

    `HHNC_ASSERT_IMP(a_id_range, o_valid, o_header_id <= hhnc_pkg::ID_W'(hhnc_pkg::NAME_COUNT))
    `HHNC_ASSERT_IMP(a_pos_sat, 1'b1, r_pos <= hhnc_pkg::POS_MAX)
    `HHNC_ASSERT_NXT(a_restart, out_load, (r_pos == '0) && (&r_alive) && o_valid)
    `HHNC_ASSERT_IMP(a_stall_src, o_stall, r_s1_valid && r_s1_last && r_out_valid)
    `HHNC_ASSERT_NXT(a_pos_step, s1_go && !r_s1_last && (r_pos < hhnc_pkg::POS_MAX), r_pos != '0)

endmodule
